[src/dmm_pkg.sv]
// Shared types, constants and helpers for the dense matrix multiply block.
`default_nettype none
package dmm_pkg;

  localparam int MAX_DIM    = 64;
  localparam int ELEM_WIDTH = 16;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int ACC_W   = PROD_W + DIM_W + 1;
  localparam int RES_W   = 32;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_WR_A = 2'd0;
  localparam logic [1:0] REQ_WR_B = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_DIM);

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic [5:0]              out_row;
    logic [5:0]              out_col;
    logic signed [RES_W-1:0] dot_sum;
    logic                    row_last;
    logic                    saturated;
  } res_t;

  // one term of the dot-product stream, travels alongside the memory read
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             row_end;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } tag_t;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/dmm_ram.sv]
// Generic one-write, one-read synchronous RAM with registered read data.
`default_nettype none
module dmm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/dmm_mac.sv]
// Multiply-accumulate pipeline with final saturation to signed 32 bits.
`default_nettype none
module dmm_mac (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dmm_pkg::tag_t                   tag_i,
  input  wire logic [dmm_pkg::ELEM_WIDTH-1:0]  a_i,
  input  wire logic [dmm_pkg::ELEM_WIDTH-1:0]  b_i,
  output logic                                 done_o,
  output logic                                 res_strobe_o,
  output dmm_pkg::res_t                        res_o
);

  logic signed [dmm_pkg::PROD_W-1:0] prod_q;
  dmm_pkg::tag_t                     tag_q;
  logic signed [dmm_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [dmm_pkg::ACC_W-dmm_pkg::RES_W:0] hi_bits;
  logic                              fits;
  logic signed [dmm_pkg::RES_W-1:0]  clip;
  logic                              strobe_q;
  dmm_pkg::res_t                     res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  always_comb begin
    if (tag_q.first) begin
      acc_d = dmm_pkg::ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + dmm_pkg::ACC_W'(prod_q);
    end
    // in range when all bits from the result sign upward agree
    hi_bits = acc_d[dmm_pkg::ACC_W-1:dmm_pkg::RES_W-1];
    fits    = (&hi_bits) || !(|hi_bits);
    if (fits) begin
      clip = acc_d[dmm_pkg::RES_W-1:0];
    end else if (acc_d[dmm_pkg::ACC_W-1]) begin
      clip = {1'b1, {(dmm_pkg::RES_W-1){1'b0}}};
    end else begin
      clip = {1'b0, {(dmm_pkg::RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag_q.valid && tag_q.last) begin
      res_q.out_row   <= tag_q.row;
      res_q.out_col   <= tag_q.col;
      res_q.dot_sum   <= clip;
      res_q.row_last  <= tag_q.row_end;
      res_q.saturated <= !fits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= tag_q.valid && tag_q.last;
    end
  end

  assign done_o       = tag_q.valid && tag_q.last && tag_q.row_end;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule
`default_nettype wire

[src/dense_matrix_multiply.sv]
// Dense matrix multiply: config registers, element stores and read-out sequencer.
// On an element write busy stays low and the next request is taken at once.
// A row read-out streams one term per cycle from the two stores, nk*nc terms in all,
// then drains through the pipeline before busy drops; results cannot stall.
// Column c's result follows its last term via read data, product and result registers.
// Async reset clears control and sets all shape registers to 64; stores are not cleared.
`default_nettype none
module dense_matrix_multiply (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire dmm_pkg::req_t                 req_i,
  output logic                               res_strobe_o,
  output dmm_pkg::res_t                      res_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dmm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dmm_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [dmm_pkg::CFG_W-1:0] rows_a_q, inner_q, cols_b_q;
  logic [dmm_pkg::CNT_W-1:0] nr, nk, nc;

  logic [dmm_pkg::DIM_W-1:0] row_q, row_d, k_q, k_d, c_q, c_d;
  logic                      accept, last_k, last_c, row_ok;
  logic                      we_a, we_b, issue;
  logic [dmm_pkg::ADDR_W-1:0]     waddr;
  logic [dmm_pkg::ELEM_WIDTH-1:0] wdata, a_data, b_data;
  dmm_pkg::tag_t             tag_d, tag_q;
  logic                      done;

  assign nr = dmm_pkg::eff_dim(rows_a_q);
  assign nk = dmm_pkg::eff_dim(inner_q);
  assign nc = dmm_pkg::eff_dim(cols_b_q);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= dmm_pkg::CFG_RESET;
      inner_q  <= dmm_pkg::CFG_RESET;
      cols_b_q <= dmm_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dmm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
        dmm_pkg::CFG_INNER:  inner_q  <= cfg_data_i;
        dmm_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // element writes, dropped outside the configured shape
  always_comb begin
    we_a  = accept && (req_i.req_type == dmm_pkg::REQ_WR_A) &&
            ({1'b0, req_i.row_index} < nr) && ({1'b0, req_i.col_index} < nk);
    we_b  = accept && (req_i.req_type == dmm_pkg::REQ_WR_B) &&
            ({1'b0, req_i.row_index} < nk) && ({1'b0, req_i.col_index} < nc);
    waddr = {req_i.row_index, req_i.col_index};
    wdata = dmm_pkg::ELEM_WIDTH'(req_i.value);
    row_ok = ({1'b0, req_i.row_index} < nr);
  end

  assign issue  = (state_q == ST_RUN);
  assign last_k = ({1'b0, k_q} + dmm_pkg::CNT_W'(1)) == nk;
  assign last_c = ({1'b0, c_q} + dmm_pkg::CNT_W'(1)) == nc;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    k_d     = k_q;
    c_d     = c_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.req_type == dmm_pkg::REQ_READ) && row_ok) begin
          state_d = ST_RUN;
          row_d   = req_i.row_index;
          k_d     = '0;
          c_d     = '0;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          k_d = '0;
          if (last_c) begin
            state_d = ST_DRAIN;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      k_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      k_q     <= k_d;
      c_q     <= c_d;
    end
  end

  always_comb begin
    tag_d.valid   = issue;
    tag_d.first   = (k_q == '0);
    tag_d.last    = last_k;
    tag_d.row_end = last_c;
    tag_d.row     = row_q;
    tag_d.col     = c_q;
  end

  // tag lines up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  dmm_ram #(
    .DEPTH(dmm_pkg::DEPTH),
    .WIDTH(dmm_pkg::ELEM_WIDTH)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i ({row_q, k_q}),
    .rdata_o (a_data)
  );

  dmm_ram #(
    .DEPTH(dmm_pkg::DEPTH),
    .WIDTH(dmm_pkg::ELEM_WIDTH)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i ({k_q, c_q}),
    .rdata_o (b_data)
  );

  dmm_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag_q),
    .a_i          (a_data),
    .b_i          (b_data),
    .done_o       (done),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire

[src/dmm_checker.sv]
// Port-level checker for the dense matrix multiply block, bound to the top level.
`default_nettype none
module dmm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire dmm_pkg::req_t                 req_i,
  input wire logic                          res_strobe_o,
  input wire dmm_pkg::res_t                 res_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  // element write requests never hold the block
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type != dmm_pkg::REQ_READ) |=> !busy)
    else $error("busy after element write request");

  // more results of the row are still to come
  a_mid_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.row_last) |-> busy)
    else $error("idle before last result of row");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result without read-out in progress");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.saturated) |->
      (res_o.dot_sum == 32'sh7fffffff || res_o.dot_sum == 32'sh80000000))
    else $error("saturated flag with unclipped sum");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !busy)
    else $error("config write taken while busy");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_i        (req_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for dense_matrix_multiply: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dmm_pkg::*;

  localparam logic [1:0]           REQ_NONE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam int                   LIMIT_CYCLES  = 500000;
  localparam int                   RANDOM_REQS   = 250;
  localparam int                   SETTLE_CYCLES = 8;
  localparam longint               SUM_MAX       = longint'(32'sh7fffffff);
  localparam longint               SUM_MIN       = longint'(32'sh80000000);

  // one row of the directed table; sel is the request type or the register index
  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  sel;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
    bit          typed;
    logic [31:0] sum;
    bit          sat;
  } step_t;

  localparam int NUM_STEPS = 33;
  localparam step_t STEPS [NUM_STEPS] = '{
    '{0, REQ_WR_A,   63, 63, 16'h7fff, 0, 0, 0},
    '{0, REQ_WR_B,   63, 63, 16'h8000, 0, 0, 0},
    '{0, REQ_NONE,   63, 63, 16'hffff, 0, 0, 0},
    // above range acts as 64, zero acts as 1, spare index ignored
    '{1, CFG_ROWS_A,  0,  0, 16'd127,  0, 0, 0},
    '{1, CFG_INNER,   0,  0, 16'd0,    0, 0, 0},
    '{1, CFG_COLS_B,  0,  0, 16'd0,    0, 0, 0},
    '{1, CFG_SPARE,   0,  0, 16'd5,    0, 0, 0},
    '{0, REQ_WR_A,   63,  0, 16'h7fff, 0, 0, 0},
    '{0, REQ_WR_B,    0,  0, 16'h7fff, 0, 0, 0},
    '{0, REQ_READ,   63,  0, 16'h0000, 1, 32'h3fff0001, 0},
    '{0, REQ_WR_A,    0,  0, 16'h8000, 0, 0, 0},
    '{0, REQ_READ,    0, 63, 16'hffff, 1, 32'hc0008000, 0},
    // outside the shape: dropped
    '{0, REQ_WR_A,    0,  1, 16'h1234, 0, 0, 0},
    '{0, REQ_WR_B,    1,  0, 16'h1234, 0, 0, 0},
    '{0, REQ_WR_B,    0,  1, 16'h1234, 0, 0, 0},
    '{1, CFG_ROWS_A,  0,  0, 16'd2,    0, 0, 0},
    '{1, CFG_INNER,   0,  0, 16'd2,    0, 0, 0},
    '{1, CFG_COLS_B,  0,  0, 16'd1,    0, 0, 0},
    '{0, REQ_WR_A,    0,  1, 16'h8000, 0, 0, 0},
    '{0, REQ_WR_B,    0,  0, 16'h8000, 0, 0, 0},
    '{0, REQ_WR_B,    1,  0, 16'h8000, 0, 0, 0},
    '{0, REQ_READ,    0,  0, 16'h0000, 1, 32'h7fffffff, 1},
    '{0, REQ_READ,    2,  0, 16'h0000, 0, 0, 0},
    '{0, REQ_WR_A,    2,  0, 16'h5555, 0, 0, 0},
    '{1, CFG_INNER,   0,  0, 16'd3,    0, 0, 0},
    '{0, REQ_WR_A,    1,  0, 16'h8000, 0, 0, 0},
    '{0, REQ_WR_A,    1,  1, 16'h8000, 0, 0, 0},
    '{0, REQ_WR_A,    1,  2, 16'h8000, 0, 0, 0},
    '{0, REQ_WR_B,    0,  0, 16'h7fff, 0, 0, 0},
    '{0, REQ_WR_B,    1,  0, 16'h7fff, 0, 0, 0},
    '{0, REQ_WR_B,    2,  0, 16'h7fff, 0, 0, 0},
    '{0, REQ_READ,    1,  0, 16'h0000, 1, 32'h80000000, 1},
    '{0, REQ_READ,   63,  0, 16'h0000, 0, 0, 0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  req_t                 req_i;
  logic                 res_strobe_o;
  res_t                 res_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  logic signed [15:0] left_elems  [DEPTH];
  logic signed [15:0] right_elems [DEPTH];
  bit                 left_loaded [DEPTH];
  bit                 right_loaded[DEPTH];
  logic [CFG_W-1:0]   shape_rows;
  logic [CFG_W-1:0]   shape_inner;
  logic [CFG_W-1:0]   shape_cols;
  res_t               row_products_q[$];
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 gap_max = 14;
  int                 random_reqs = 0;

  dense_matrix_multiply u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("dense_matrix_multiply: mismatch");
      $finish;
    end
  end

  function automatic int shape_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    return (v > CFG_W'(MAX_DIM)) ? MAX_DIM : int'(v);
  endfunction

  function automatic logic [15:0] random_elem();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // store updates and row dot products for one accepted request
  task automatic apply_request(input req_t r);
    int     nr;
    int     nk;
    int     nc;
    longint acc;
    res_t   p;
    nr = shape_dim(shape_rows);
    nk = shape_dim(shape_inner);
    nc = shape_dim(shape_cols);
    case (r.req_type)
      REQ_WR_A: begin
        if (r.row_index < nr && r.col_index < nk) begin
          left_elems[{r.row_index, r.col_index}]  = r.value;
          left_loaded[{r.row_index, r.col_index}] = 1'b1;
        end
      end
      REQ_WR_B: begin
        if (r.row_index < nk && r.col_index < nc) begin
          right_elems[{r.row_index, r.col_index}]  = r.value;
          right_loaded[{r.row_index, r.col_index}] = 1'b1;
        end
      end
      REQ_READ: begin
        if (r.row_index < nr) begin
          for (int c = 0; c < nc; c++) begin
            acc = 0;
            // at most 64 terms of 2^30: the wide accumulator never clips
            for (int k = 0; k < nk; k++) begin
              acc += longint'(left_elems[{r.row_index, 6'(k)}]) *
                     longint'(right_elems[{6'(k), 6'(c)}]);
            end
            p.out_row   = r.row_index;
            p.out_col   = 6'(c);
            p.row_last  = (c == nc - 1);
            p.saturated = (acc > SUM_MAX) || (acc < SUM_MIN);
            if (acc > SUM_MAX) begin
              p.dot_sum = 32'sh7fffffff;
            end else if (acc < SUM_MIN) begin
              p.dot_sum = 32'sh80000000;
            end else begin
              p.dot_sum = acc[31:0];
            end
            row_products_q.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  // returns at the edge that accepts the request, start still high
  task automatic issue(input req_t r);
    int gap;
    bit taken;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [5:0] row,
                              input logic [5:0] col, input logic [15:0] value);
    req_t r;
    r = '{req_type: kind, row_index: row, col_index: col, value: value};
    issue(r);
    apply_request(r);
    if (kind != REQ_NONE) random_reqs++;
  endtask

  // leaves cfg_valid_i high on return; the caller lowers it after the last write
  task automatic write_shape(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int gap;
    bit taken;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      CFG_ROWS_A: shape_rows  = val;
      CFG_INNER:  shape_inner = val;
      CFG_COLS_B: shape_cols  = val;
      default: ;
    endcase
  endtask

  // drop start, wait for all row results and let the pipeline drain
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (row_products_q.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_strobe_o) begin
      if (row_products_q.size() == 0) begin
        errors++;
        $display("%0t: unrequested result row=%0d col=%0d sum=%0d last=%0b sat=%0b",
                 $time, res_o.out_row, res_o.out_col, res_o.dot_sum, res_o.row_last,
                 res_o.saturated);
      end else begin
        want = row_products_q.pop_front();
        if (res_o.out_row !== want.out_row || res_o.out_col !== want.out_col ||
            res_o.dot_sum !== want.dot_sum || res_o.row_last !== want.row_last ||
            res_o.saturated !== want.saturated) begin
          errors++;
          $display("%0t: expected row=%0d col=%0d sum=%0d last=%0b sat=%0b", $time,
                   want.out_row, want.out_col, want.dot_sum, want.row_last, want.saturated);
          $display("%0t: actual   row=%0d col=%0d sum=%0d last=%0b sat=%0b", $time,
                   res_o.out_row, res_o.out_col, res_o.dot_sum, res_o.row_last,
                   res_o.saturated);
        end
      end
    end
  end

  initial begin
    step_t            s;
    req_t             r;
    bit               in_cfg;
    int               big;
    int               nr;
    int               nk;
    int               nc;
    int               pick;
    logic [CFG_W-1:0] dims [3];

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    shape_rows  = CFG_RESET;
    shape_inner = CFG_RESET;
    shape_cols  = CFG_RESET;
    in_cfg      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (STEPS[i]) begin
      s = STEPS[i];
      if (s.is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_shape(s.sel, CFG_W'(s.value));
      end else begin
        if (in_cfg) cfg_valid_i <= 1'b0;
        in_cfg = 1'b0;
        r = '{req_type: s.sel, row_index: s.row, col_index: s.col, value: s.value};
        issue(r);
        if (s.typed) begin
          row_products_q.push_back('{out_row: s.row, out_col: '0, dot_sum: s.sum,
                                     row_last: 1'b1, saturated: s.sat});
        end else begin
          apply_request(r);
        end
      end
    end

    while (random_reqs < RANDOM_REQS) begin
      // at most one dimension large, the other two kept tiny
      big     = $urandom_range(0, 5);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      for (int d = 0; d < 3; d++) begin
        if (d == big) begin
          dims[d] = ($urandom_range(0, 1) == 1) ? CFG_W'(64) : CFG_W'($urandom_range(65, 127));
        end else if (big < 3) begin
          dims[d] = CFG_W'($urandom_range(1, 2));
        end else if ($urandom_range(0, 15) == 0) begin
          dims[d] = '0;
        end else begin
          dims[d] = CFG_W'($urandom_range(1, 6));
        end
      end
      settle();
      write_shape(CFG_ROWS_A, dims[0]);
      write_shape(CFG_INNER, dims[1]);
      write_shape(CFG_COLS_B, dims[2]);
      if ($urandom_range(0, 7) == 0) write_shape(CFG_SPARE, CFG_W'($urandom));
      cfg_valid_i <= 1'b0;
      nr = shape_dim(shape_rows);
      nk = shape_dim(shape_inner);
      nc = shape_dim(shape_cols);

      // load every element the new shape can read
      for (int a = 0; a < nr; a++)
        for (int k = 0; k < nk; k++)
          if (!left_loaded[{6'(a), 6'(k)}])
            send_request(REQ_WR_A, 6'(a), 6'(k), random_elem());
      for (int k = 0; k < nk; k++)
        for (int c = 0; c < nc; c++)
          if (!right_loaded[{6'(k), 6'(c)}])
            send_request(REQ_WR_B, 6'(k), 6'(c), random_elem());

      repeat (24) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_request(REQ_READ, 6'($urandom_range(0, nr - 1)), 6'($urandom), 16'($urandom));
        end else if (pick < 55) begin
          send_request(REQ_WR_A, 6'($urandom_range(0, nr - 1)), 6'($urandom_range(0, nk - 1)),
                       random_elem());
        end else if (pick < 70) begin
          send_request(REQ_WR_B, 6'($urandom_range(0, nk - 1)), 6'($urandom_range(0, nc - 1)),
                       random_elem());
        end else if (pick < 80) begin
          // full index range: mostly dropped, occasionally in shape
          send_request($urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A, 6'($urandom),
                       6'($urandom), 16'($urandom));
        end else if (pick < 90) begin
          send_request(REQ_READ, 6'($urandom), 6'($urandom), 16'($urandom));
        end else begin
          send_request(REQ_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("dense_matrix_multiply: match");
    end else begin
      $display("dense_matrix_multiply: mismatch");
    end
    $finish;
  end

endmodule
